// ===== rtl/lcs_pkg.sv =====
package lcs_pkg;

  // Width of every operand and of the solution.
  localparam int unsigned OPERAND_WIDTH = 32;

  typedef logic [OPERAND_WIDTH-1:0] operand_t;

  // One input transaction.
  typedef struct packed {
    operand_t coefficient;
    operand_t target;
    operand_t modulus;
  } lcs_in_t;

  // One result transaction.
  typedef struct packed {
    operand_t solution;
    logic     no_solution;
  } lcs_out_t;

  // Modular addition of two residues below n (n at least one).
  function automatic operand_t add_mod(operand_t x, operand_t y, operand_t n);
    operand_t gap;
    gap = n - y;
    return (x >= gap) ? (x - gap) : (x + y);
  endfunction

  // Modular subtraction of two residues below n.
  function automatic operand_t sub_mod(operand_t x, operand_t y, operand_t n);
    return (x >= y) ? (x - y) : (x + (n - y));
  endfunction

endpackage

// ===== rtl/lcs_div.sv =====
module lcs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lcs_pkg::operand_t dividend_i,
  input  lcs_pkg::operand_t divisor_i,
  output logic              done_o,
  output lcs_pkg::operand_t quot_o,
  output lcs_pkg::operand_t rem_o
);
  import lcs_pkg::*;

  localparam int unsigned CntW = $clog2(OPERAND_WIDTH);

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_ALIGN,
    DIV_REDUCE
  } div_state_e;

  div_state_e            state_q;
  operand_t              rem_q;
  operand_t              quot_q;
  operand_t              dvs_q;
  logic [CntW-1:0]       shift_q;
  logic                  done_q;
  logic [OPERAND_WIDTH:0] dbl;
  logic [OPERAND_WIDTH:0] rem_ext;
  logic                  fits;

  // The doubled divisor is compared one bit wider so that it never wraps.
  assign dbl     = {dvs_q, 1'b0};
  assign rem_ext = {1'b0, rem_q};
  assign fits    = (rem_q >= dvs_q);

  // Align the divisor under the dividend, then take one quotient bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        DIV_IDLE: begin
          if (start_i) begin
            rem_q   <= dividend_i;
            dvs_q   <= divisor_i;
            quot_q  <= '0;
            shift_q <= '0;
            state_q <= DIV_ALIGN;
          end
        end
        DIV_ALIGN: begin
          if (dbl <= rem_ext) begin
            dvs_q   <= dbl[OPERAND_WIDTH-1:0];
            shift_q <= shift_q + CntW'(1);
          end else begin
            state_q <= DIV_REDUCE;
          end
        end
        DIV_REDUCE: begin
          if (fits) begin
            rem_q <= rem_q - dvs_q;
          end
          quot_q <= {quot_q[OPERAND_WIDTH-2:0], fits};
          if (shift_q == '0) begin
            done_q  <= 1'b1;
            state_q <= DIV_IDLE;
          end else begin
            dvs_q   <= dvs_q >> 1;
            shift_q <= shift_q - CntW'(1);
          end
        end
        default: state_q <= DIV_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  // The sequencer never asks for a division by zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> divisor_i != '0)
    else $error("lcs_div: division by zero requested");

endmodule

// ===== rtl/lcs_mulmod.sv =====
module lcs_mulmod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lcs_pkg::operand_t x_i,
  input  lcs_pkg::operand_t y_i,
  input  lcs_pkg::operand_t n_i,
  output logic              done_o,
  output lcs_pkg::operand_t prod_o
);
  import lcs_pkg::*;

  typedef enum logic {
    MM_IDLE,
    MM_RUN
  } mm_state_e;

  mm_state_e state_q;
  operand_t  acc_q;
  operand_t  x_q;
  operand_t  y_q;
  operand_t  n_q;
  logic      done_q;

  // Shift-and-add product modulo n: scan the multiplier from its low end and
  // stop as soon as no set bits remain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        MM_IDLE: begin
          if (start_i) begin
            acc_q   <= '0;
            x_q     <= x_i;
            y_q     <= y_i;
            n_q     <= n_i;
            state_q <= MM_RUN;
          end
        end
        MM_RUN: begin
          if (y_q == '0) begin
            done_q  <= 1'b1;
            state_q <= MM_IDLE;
          end else begin
            if (y_q[0]) begin
              acc_q <= add_mod(acc_q, x_q, n_q);
            end
            x_q <= add_mod(x_q, x_q, n_q);
            y_q <= y_q >> 1;
          end
        end
        default: state_q <= MM_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

  // The multiplicand must already be a residue of the modulus.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> x_i < n_i)
    else $error("lcs_mulmod: multiplicand not reduced");

endmodule

// ===== rtl/linear_congruence_solver_top.sv =====
// Linear congruence solver: finds the smallest non-negative x with
// coefficient * x == target (mod modulus), or flags that none exists.
//
// Input: a transaction is taken when start is high while busy is low. busy
// then stays high until the result has been produced; no new transaction
// is taken meanwhile.
// Output: result_valid_o is high for exactly one cycle with the result on
// result_o. The receiver cannot stall; the result must be taken in that cycle.
// A new transaction may be started in the cycle the result is shown.
//
// Sequence: one set-up step, then per extended Euclid step one division and
// one modular multiply, followed, when the gcd divides the target, by four
// divisions and one modular multiply for the final reduction. The
// shift-subtract divider and the shift-and-add modular multiplier are used
// one at a time by the sequencer.
//
// Reset returns the sequencer and both arithmetic units to idle; no
// transaction is in flight afterwards.
module linear_congruence_solver_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  lcs_pkg::lcs_in_t item_i,
  output logic             result_valid_o,
  output lcs_pkg::lcs_out_t result_o
);
  import lcs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_EUC,
    S_EUC_DIV,
    S_EUC_MUL,
    S_T_DIV,
    S_N_DIV,
    S_S_DIV,
    S_TQ_DIV,
    S_F_MUL
  } seq_state_e;

  seq_state_e state_q;
  lcs_in_t    item_q;
  operand_t   r0_q;
  operand_t   r1_q;
  operand_t   s0_q;
  operand_t   s1_q;
  operand_t   tq_q;
  operand_t   n_q;
  logic       valid_q;
  lcs_out_t   result_q;

  logic       div_start_q;
  operand_t   div_a_q;
  operand_t   div_b_q;
  logic       div_done;
  operand_t   div_quot;
  operand_t   div_rem;

  logic       mm_start_q;
  operand_t   mm_x_q;
  operand_t   mm_y_q;
  operand_t   mm_n_q;
  logic       mm_done;
  operand_t   mm_prod;

  // Arithmetic units shared by the Euclid and reduction steps of the sequence.
  lcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  lcs_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start_q),
    .x_i     (mm_x_q),
    .y_i     (mm_y_q),
    .n_i     (mm_n_q),
    .done_o  (mm_done),
    .prod_o  (mm_prod)
  );

  // Sequencer: extended Euclid with the Bezout coefficient kept modulo m,
  // then the divisibility check and the final reduction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= 1'b0;
      div_start_q <= 1'b0;
      mm_start_q  <= 1'b0;
    end else begin
      valid_q     <= 1'b0;
      div_start_q <= 1'b0;
      mm_start_q  <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            item_q  <= item_i;
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          if (item_q.modulus == '0) begin
            // The congruence is undefined for a zero modulus.
            result_q.solution    <= '0;
            result_q.no_solution <= 1'b1;
            valid_q              <= 1'b1;
            state_q              <= S_IDLE;
          end else begin
            r0_q    <= item_q.coefficient;
            r1_q    <= item_q.modulus;
            s0_q    <= (item_q.modulus == OPERAND_WIDTH'(1)) ? '0 : OPERAND_WIDTH'(1);
            s1_q    <= '0;
            state_q <= S_EUC;
          end
        end
        S_EUC: begin
          div_start_q <= 1'b1;
          if (r1_q == '0) begin
            // r0 now holds the gcd; test whether it divides the target.
            div_a_q <= item_q.target;
            div_b_q <= r0_q;
            state_q <= S_T_DIV;
          end else begin
            div_a_q <= r0_q;
            div_b_q <= r1_q;
            state_q <= S_EUC_DIV;
          end
        end
        S_EUC_DIV: begin
          if (div_done) begin
            r0_q       <= r1_q;
            r1_q       <= div_rem;
            mm_start_q <= 1'b1;
            mm_x_q     <= s1_q;
            mm_y_q     <= div_quot;
            mm_n_q     <= item_q.modulus;
            state_q    <= S_EUC_MUL;
          end
        end
        S_EUC_MUL: begin
          if (mm_done) begin
            s0_q    <= s1_q;
            s1_q    <= sub_mod(s0_q, mm_prod, item_q.modulus);
            state_q <= S_EUC;
          end
        end
        S_T_DIV: begin
          if (div_done) begin
            if (div_rem != '0) begin
              result_q.solution    <= '0;
              result_q.no_solution <= 1'b1;
              valid_q              <= 1'b1;
              state_q              <= S_IDLE;
            end else begin
              tq_q        <= div_quot;
              div_start_q <= 1'b1;
              div_a_q     <= item_q.modulus;
              div_b_q     <= r0_q;
              state_q     <= S_N_DIV;
            end
          end
        end
        S_N_DIV: begin
          // Reduced modulus n = m / g.
          if (div_done) begin
            n_q         <= div_quot;
            div_start_q <= 1'b1;
            div_a_q     <= s0_q;
            div_b_q     <= div_quot;
            state_q     <= S_S_DIV;
          end
        end
        S_S_DIV: begin
          if (div_done) begin
            s0_q        <= div_rem;
            div_start_q <= 1'b1;
            div_a_q     <= tq_q;
            div_b_q     <= n_q;
            state_q     <= S_TQ_DIV;
          end
        end
        S_TQ_DIV: begin
          if (div_done) begin
            mm_start_q <= 1'b1;
            mm_x_q     <= s0_q;
            mm_y_q     <= div_rem;
            mm_n_q     <= n_q;
            state_q    <= S_F_MUL;
          end
        end
        S_F_MUL: begin
          if (mm_done) begin
            result_q.solution    <= mm_prod;
            result_q.no_solution <= 1'b0;
            valid_q              <= 1'b1;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  // A result is only ever shown once the sequencer has gone idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while still busy");

  // An accepted transaction always occupies the block in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("transaction accepted but block not busy");

  // A missing solution is always reported with a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.no_solution |-> result_o.solution == '0)
    else $error("no-solution result carries a non-zero value");

  // The Bezout coefficient stays a residue of the modulus throughout Euclid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EUC_MUL |-> s0_q < item_q.modulus)
    else $error("Bezout coefficient left its residue range");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  import lcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 10_000_000;
  localparam int unsigned DRAIN_CYCLES = 2000;
  localparam int unsigned RANDOM_ITEMS = 1225;

  // Directed rows carry either a hand-written answer or are left to the solver.
  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct packed {
    lcs_in_t  stim;
    logic     by_hand;
    lcs_out_t want;
  } directed_row_t;

  localparam int unsigned NUM_DIRECTED = 25;

  localparam directed_row_t DIRECTED[NUM_DIRECTED] = '{
    '{'{32'd3, 32'd4, 32'd7}, TYPED, '{32'd6, 1'b0}},
    '{'{32'd5, 32'd3, 32'd0}, TYPED, '{32'd0, 1'b1}},
    '{'{32'd0, 32'd0, 32'd0}, TYPED, '{32'd0, 1'b1}},
    '{'{32'd0, 32'd14, 32'd7}, TYPED, '{32'd0, 1'b0}},
    '{'{32'd0, 32'd5, 32'd7}, TYPED, '{32'd0, 1'b1}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1}, TYPED, '{32'd0, 1'b0}},
    '{'{32'd6, 32'd12, 32'd6}, TYPED, '{32'd0, 1'b0}},
    '{'{32'd4, 32'd3, 32'd6}, TYPED, '{32'd0, 1'b1}},
    '{'{32'd4, 32'd2, 32'd6}, TYPED, '{32'd2, 1'b0}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, TYPED, '{32'd0, 1'b0}},
    '{'{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE}, TYPED, '{32'd1, 1'b0}},
    '{'{32'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFF}, TYPED, '{32'hFFFF_FFFE, 1'b0}},
    '{'{32'h8000_0000, 32'd0, 32'h8000_0000}, TYPED, '{32'd0, 1'b0}},
    '{'{32'd2, 32'd1, 32'h8000_0000}, TYPED, '{32'd0, 1'b1}},
    '{'{32'd3, 32'd0, 32'd7}, TYPED, '{32'd0, 1'b0}},
    '{'{32'd7, 32'd5, 32'd3}, TYPED, '{32'd2, 1'b0}},
    '{'{32'd0, 32'd0, 32'd1}, TYPED, '{32'd0, 1'b0}},
    '{'{32'hFFFF_FFFF, 32'd0, 32'd0}, TYPED, '{32'd0, 1'b1}},
    '{'{32'd2971215073, 32'd12345, 32'd1836311903}, PREDICTED, '0},
    '{'{32'd1836311903, 32'hFFFF_FFFF, 32'd2971215073}, PREDICTED, '0},
    '{'{32'h8000_0000, 32'h4000_0000, 32'hFFFF_FFFF}, PREDICTED, '0},
    '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678}, PREDICTED, '0},
    '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'hFEDC_BA98}, PREDICTED, '0},
    '{'{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, PREDICTED, '0},
    '{'{32'd12, 32'd18, 32'd30}, PREDICTED, '0}
  };

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  lcs_in_t  item_i;
  logic     result_valid_o;
  lcs_out_t result_o;

  lcs_out_t    pending_answers[$];
  lcs_out_t    oldest_answer;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned solvable_seen;
  int unsigned unsolvable_seen;
  int unsigned burst_left;
  int unsigned cycle_count;

  linear_congruence_solver_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // Free-running clock, 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Solves coefficient * x == target (mod modulus) by extended Euclid, keeping
  // the Bezout coefficient of the coefficient reduced modulo the modulus.
  function automatic lcs_out_t solve_congruence(lcs_in_t it);
    lcs_out_t    res;
    logic [63:0] m;
    logic [63:0] rem_a;
    logic [63:0] rem_b;
    logic [63:0] bez_a;
    logic [63:0] bez_b;
    logic [63:0] quot;
    logic [63:0] nxt;
    logic [63:0] g;
    logic [63:0] n;
    res.solution    = '0;
    res.no_solution = 1'b1;
    m = 64'(it.modulus);
    if (m == 0) begin
      return res;
    end
    rem_a = 64'(it.coefficient);
    rem_b = m;
    bez_a = 64'd1 % m;
    bez_b = 64'd0;
    while (rem_b != 0) begin
      quot  = rem_a / rem_b;
      nxt   = rem_a % rem_b;
      rem_a = rem_b;
      rem_b = nxt;
      // Both factors stay below 2^32, so the product fits in 64 bits.
      nxt   = (bez_a + m - ((quot % m) * bez_b) % m) % m;
      bez_a = bez_b;
      bez_b = nxt;
    end
    g = rem_a;
    if ((64'(it.target) % g) != 0) begin
      return res;
    end
    n = m / g;
    res.solution    = operand_t'(((bez_a % n) * ((64'(it.target) / g) % n)) % n);
    res.no_solution = 1'b0;
    return res;
  endfunction

  // Operand with a bias towards zero, small values, the top of the range and
  // values of random bit length.
  function automatic operand_t rand_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return operand_t'('1) - operand_t'($urandom_range(0, 3));
      2:       return operand_t'($urandom_range(1, 16));
      3, 4:    return operand_t'($urandom) >> $urandom_range(0, 31);
      default: return operand_t'($urandom);
    endcase
  endfunction

  // About half of the items share a common factor across all three fields, so
  // that the path with a non-trivial gcd is reached often.
  function automatic lcs_in_t random_item();
    lcs_in_t  it;
    operand_t g;
    operand_t span;
    it.coefficient = rand_operand();
    it.target      = rand_operand();
    it.modulus     = rand_operand();
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 2))
        0:       g = operand_t'($urandom_range(1, 16));
        1:       g = operand_t'(1) << $urandom_range(0, 20);
        default: g = operand_t'($urandom_range(1, 65535));
      endcase
      span = operand_t'('1) / g;
      it.coefficient = (operand_t'($urandom) % span) * g;
      it.target      = (operand_t'($urandom) % span) * g;
      it.modulus     = (operand_t'($urandom) % span) * g;
      // Now and then knock the target off the common factor.
      if (g > 1 && $urandom_range(0, 3) == 0) begin
        it.target = it.target + operand_t'($urandom_range(1, g - 1));
      end
    end
    return it;
  endfunction

  // Offers one transaction and waits until the block is no longer busy.
  task automatic send_item(input lcs_in_t it, input lcs_out_t want);
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    pending_answers.push_back(want);
    items_sent++;
  endtask

  // Bursts of back-to-back transactions, separated by short or long gaps so
  // that a new offer lands on every phase of the block's work.
  task automatic sender_idle();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 12);
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 10)
                                        : $urandom_range(11, 1500);
      start  <= 1'b0;
      item_i <= lcs_in_t'({$urandom, $urandom, $urandom});
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Every result is matched against the oldest outstanding answer.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_answers.size() == 0) begin
        $error("result with nothing outstanding: solution %0d, no_solution %0b",
               result_o.solution, result_o.no_solution);
        errors++;
      end else begin
        oldest_answer = pending_answers.pop_front();
        if (oldest_answer.no_solution) begin
          unsolvable_seen++;
        end else begin
          solvable_seen++;
        end
        if (result_o.solution !== oldest_answer.solution) begin
          $error("solution mismatch: expected %0d, actual %0d",
                 oldest_answer.solution, result_o.solution);
          errors++;
        end
        if (result_o.no_solution !== oldest_answer.no_solution) begin
          $error("no_solution mismatch: expected %0b, actual %0b",
                 oldest_answer.no_solution, result_o.no_solution);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Reset, directed table, random transactions, then drain.
  initial begin
    lcs_in_t it;
    rst_ni          = 1'b0;
    start           = 1'b0;
    item_i          = '0;
    errors          = 0;
    items_sent      = 0;
    results_seen    = 0;
    solvable_seen   = 0;
    unsolvable_seen = 0;
    burst_left      = 0;
    cycle_count     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_item(DIRECTED[i].stim, DIRECTED[i].by_hand ? DIRECTED[i].want
                                                      : solve_congruence(DIRECTED[i].stim));
      sender_idle();
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      it = random_item();
      send_item(it, solve_congruence(it));
      sender_idle();
    end
    start <= 1'b0;

    while (pending_answers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d transactions (%0d from the directed table) in %0d cycles.",
             items_sent, NUM_DIRECTED, cycle_count);
    $display("Checked %0d results: %0d solvable, %0d without a solution.",
             results_seen, solvable_seen, unsolvable_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lcs_pkg.sv
rtl/lcs_div.sv
rtl/lcs_mulmod.sv
rtl/linear_congruence_solver_top.sv
sim/tb.sv
